>>> hw/rtl/icmt_pkg.sv
// Shared types, constants and helpers for the I/O channel map table.
// Used by every module of the block; depends on nothing.
package icmt_pkg;

	// Table geometry and field widths.
	localparam int MAX_ENTRIES_DEF = 32;
	localparam int RESULT_CAP = 32;
	localparam int KW = $clog2(RESULT_CAP + 1);
	localparam int TOTAL_W = 13;
	localparam int GROW_STEPS = TOTAL_W - 3;
	localparam int STEP_W = $clog2(GROW_STEPS + 1);

	// Operation codes carried in the request.
	typedef enum logic [2:0] {
		MODE_ADD   = 3'd0,
		MODE_FIND  = 3'd1,
		MODE_READ  = 3'd2,
		MODE_LIST  = 3'd3,
		MODE_CLEAR = 3'd4
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  node_id;
		logic [7:0]  module_id;
		logic [15:0] channel_id;
		logic [6:0]  size_bits;
		logic [15:0] byte_offset;
		logic [2:0]  bit_position;
		logic [4:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  out_size_bits;
		logic [15:0] out_byte_offset;
		logic [2:0]  out_bit_position;
		logic [5:0]  entry_count;
		logic [10:0] image_bytes;
		logic        table_full;
		logic        last;
	} rsp_t;

	// One stored table row.
	typedef struct packed {
		logic [7:0]  node_id;
		logic [7:0]  module_id;
		logic [15:0] channel_id;
		logic [6:0]  size_bits;
		logic [15:0] byte_offset;
		logic [2:0]  bit_position;
	} entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_GROW,
		S_SCAN,
		S_CHECK,
		S_FINISH,
		S_OUT_MID,
		S_OUT
	} state_t;

	// What the output register takes.
	typedef enum logic [3:0] {
		OUT_NONE,
		OUT_ADD,
		OUT_FULL,
		OUT_ROW,
		OUT_MISS,
		OUT_CLEAR,
		OUT_PEND_MID,
		OUT_PEND_LAST,
		OUT_LIST_NONE
	} out_sel_t;

	typedef struct packed {
		logic     req_load;
		logic     tbl_write;
		logic     tbl_clear;
		logic     grow_go;
		logic     grow_sub;
		logic     add_commit;
		logic     list_commit;
		logic     idx_inc;
		logic     idx_load_read;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  add_full;
		logic  read_ok;
		logic  scan_more;
		logic  hit;
		logic  grow_done;
		logic  pend_valid;
	} stat_t;

	// Bit total rounded up to 32 bits, expressed in bytes.
	function automatic logic [10:0] image_of(logic [TOTAL_W-1:0] t);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, t} + (TOTAL_W+1)'(31);
		return {sum[TOTAL_W:5], 2'b00};
	endfunction

endpackage

>>> hw/rtl/io_channel_map_table.sv
// I/O channel map table, top level: joins the controller and the datapath.
// Depends on icmt_pkg, icmt_ctrl and icmt_dp.
//
// One request is handled at a time; req_ready is high only while idle.
// Add writes the row and updates the bit total; when the size is a nonzero
// multiple of 8, the total is first padded by a serial remainder unit that
// takes one bit a cycle over 10 bits. Clear, unused codes and a read past
// the stored entries answer straight from dispatch; a read of a stored row
// first fetches it through the registered memory port. Find and listing
// scan the table entry by entry through that port; a listing also updates
// the subset total for each match and waits for the transfer of each
// earlier match. Each result waits in an output register until
// transferred. No clearing pass is needed after reset.
module io_channel_map_table #(
	parameter int MAX_ENTRIES = icmt_pkg::MAX_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  icmt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output icmt_pkg::rsp_t rsp
);
	import icmt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	icmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	icmt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

>>> hw/rtl/icmt_grow.sv
// Bit total update unit: pads the total up to a multiple of a byte-aligned
// size with a serial remainder, then adds the size. Depends on icmt_pkg.
module icmt_grow (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [icmt_pkg::TOTAL_W-1:0] total_in,
	input  logic [6:0]                  size_in,
	output logic                        done,
	output logic [icmt_pkg::TOTAL_W-1:0] result
);
	import icmt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [3:0]          r_q;
	logic [GROW_STEPS-1:0] sh_q;
	logic [TOTAL_W-1:0]  tot_q;
	logic [6:0]          size_q;
	logic [TOTAL_W-1:0]  res_q;

	logic [4:0]          r_sh;
	logic [4:0]          r_nx;
	logic [6:0]          rem;
	logic [6:0]          pad;
	logic [TOTAL_W-1:0]  fin;
	logic                pad_need;

	// One restoring remainder step on the total in units of bytes.
	always_comb begin
		r_sh = {r_q, sh_q[GROW_STEPS-1]};
		if (r_sh >= {1'b0, size_q[6:3]}) begin
			r_nx = r_sh - {1'b0, size_q[6:3]};
		end else begin
			r_nx = r_sh;
		end
		rem = {r_nx[3:0], tot_q[2:0]};
		pad = (rem != 7'd0) ? (size_q - rem) : 7'd0;
		fin = tot_q + TOTAL_W'(pad) + TOTAL_W'(size_q);
		pad_need = (size_in != 7'd0) && (size_in[2:0] == 3'd0);
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (pad_need) begin
					busy_q <= 1'b1;
					cnt_q  <= STEP_W'(GROW_STEPS);
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			tot_q  <= total_in;
			size_q <= size_in;
			r_q    <= 4'd0;
			sh_q   <= total_in[TOTAL_W-1:3];
			res_q  <= total_in + TOTAL_W'(size_in);
		end else if (busy_q) begin
			r_q  <= r_nx[3:0];
			sh_q <= {sh_q[GROW_STEPS-2:0], 1'b0};
			if (cnt_q == STEP_W'(1)) begin
				res_q <= fin;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> hw/rtl/icmt_dp.sv
// Datapath: request register, entry memory, counters, bit totals and the
// result registers. Depends on icmt_pkg and icmt_grow.
module icmt_dp #(
	parameter int MAX_ENTRIES = icmt_pkg::MAX_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  icmt_pkg::req_t  req,
	input  icmt_pkg::cmd_t  cmd,
	output icmt_pkg::stat_t stat,
	output icmt_pkg::rsp_t  rsp
);
	import icmt_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	entry_t             mem [MAX_ENTRIES];
	entry_t             rd_q;
	req_t               req_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [KW-1:0]      k_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] sub_q;
	rsp_t               pend_q;
	logic               pend_v_q;
	rsp_t               out_q;

	logic               grow_done;
	logic [TOTAL_W-1:0] grow_res;
	logic [TOTAL_W-1:0] grow_tot;
	logic [6:0]         grow_size;
	logic [CW-1:0]      count_inc;
	rsp_t               row_rsp;
	rsp_t               base_rsp;
	rsp_t               pend_nx;
	rsp_t               out_nx;

	icmt_grow u_grow (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.grow_go),
		.total_in (grow_tot),
		.size_in  (grow_size),
		.done     (grow_done),
		.result   (grow_res)
	);

	// Operand select for the total unit and common result shapes.
	always_comb begin
		grow_tot  = cmd.grow_sub ? sub_q : total_q;
		grow_size = cmd.grow_sub ? rd_q.size_bits : req_q.size_bits;
		count_inc = count_q + CW'(1);

		base_rsp = '0;
		base_rsp.entry_count = 6'(count_q);
		base_rsp.image_bytes = image_of(total_q);
		base_rsp.last        = 1'b1;

		row_rsp = base_rsp;
		row_rsp.found            = 1'b1;
		row_rsp.out_size_bits    = rd_q.size_bits;
		row_rsp.out_byte_offset  = rd_q.byte_offset;
		row_rsp.out_bit_position = rd_q.bit_position;
	end

	// Status toward the controller.
	always_comb begin
		stat.mode       = req_q.mode;
		stat.add_full   = (count_q >= CW'(MAX_ENTRIES));
		stat.read_ok    = ({2'b00, req_q.entry_index} < 7'(count_q));
		stat.scan_more  = (idx_q < count_q) &&
			((req_q.mode != MODE_LIST) || (k_q < KW'(RESULT_CAP)));
		if (req_q.mode == MODE_LIST) begin
			stat.hit = (rd_q.node_id == req_q.node_id) &&
				(rd_q.module_id == req_q.module_id);
		end else if (req_q.mode == MODE_FIND) begin
			stat.hit = (rd_q.node_id == req_q.node_id) &&
				(rd_q.module_id == req_q.module_id) &&
				(rd_q.channel_id == req_q.channel_id);
		end else begin
			stat.hit = 1'b1;
		end
		stat.grow_done  = grow_done;
		stat.pend_valid = pend_v_q;
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.tbl_write) begin
			mem[count_q[AW-1:0]] <= '{
				node_id:      req_q.node_id,
				module_id:    req_q.module_id,
				channel_id:   req_q.channel_id,
				size_bits:    req_q.size_bits,
				byte_offset:  req_q.byte_offset,
				bit_position: req_q.bit_position
			};
		end
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// Table bookkeeping and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			total_q  <= '0;
			idx_q    <= '0;
			k_q      <= '0;
			sub_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.req_load) begin
				idx_q    <= '0;
				k_q      <= '0;
				sub_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.idx_load_read) begin
				idx_q <= CW'(req_q.entry_index);
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.tbl_clear) begin
				count_q <= '0;
				total_q <= '0;
			end
			if (cmd.add_commit) begin
				count_q <= count_inc;
				total_q <= grow_res;
			end
			if (cmd.list_commit) begin
				sub_q    <= grow_res;
				k_q      <= k_q + KW'(1);
				idx_q    <= idx_q + CW'(1);
				pend_v_q <= 1'b1;
			end
		end
	end

	// Next values of the pending listing result and the output register.
	always_comb begin
		pend_nx             = row_rsp;
		pend_nx.image_bytes = image_of(grow_res);
		pend_nx.last        = 1'b0;

		out_nx = out_q;
		unique case (cmd.out_sel)
			OUT_NONE: begin
			end
			OUT_ADD: begin
				out_nx                  = base_rsp;
				out_nx.found            = 1'b1;
				out_nx.out_size_bits    = req_q.size_bits;
				out_nx.out_byte_offset  = req_q.byte_offset;
				out_nx.out_bit_position = req_q.bit_position;
				out_nx.entry_count      = 6'(count_inc);
				out_nx.image_bytes      = image_of(grow_res);
			end
			OUT_FULL: begin
				out_nx            = base_rsp;
				out_nx.table_full = 1'b1;
			end
			OUT_ROW: begin
				out_nx = row_rsp;
			end
			OUT_MISS: begin
				out_nx = base_rsp;
			end
			OUT_CLEAR: begin
				out_nx      = '0;
				out_nx.last = 1'b1;
			end
			OUT_PEND_MID: begin
				out_nx = pend_q;
			end
			OUT_PEND_LAST: begin
				out_nx      = pend_q;
				out_nx.last = 1'b1;
			end
			OUT_LIST_NONE: begin
				out_nx             = base_rsp;
				out_nx.image_bytes = '0;
			end
			default: begin
			end
		endcase
	end

	// Request, pending listing result and output registers.
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		if (cmd.list_commit) begin
			pend_q <= pend_nx;
		end
		out_q <= out_nx;
	end

	assign rsp = out_q;

endmodule

>>> hw/rtl/icmt_ctrl.sv
// Controller state machine: sequences each request through dispatch, table
// scan, total update and result transfer. Depends on icmt_pkg.
module icmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  icmt_pkg::stat_t stat,
	output icmt_pkg::cmd_t  cmd
);
	import icmt_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (stat.mode)
					MODE_ADD:  state_nx = stat.add_full ? S_OUT : S_GROW;
					MODE_FIND: state_nx = S_SCAN;
					MODE_LIST: state_nx = S_SCAN;
					MODE_READ: state_nx = stat.read_ok ? S_SCAN : S_OUT;
					default:   state_nx = S_OUT;
				endcase
			end
			S_GROW: begin
				if (stat.grow_done) begin
					if (stat.mode == MODE_LIST) begin
						state_nx = stat.pend_valid ? S_OUT_MID : S_SCAN;
					end else begin
						state_nx = S_OUT;
					end
				end
			end
			S_SCAN: begin
				state_nx = stat.scan_more ? S_CHECK : S_FINISH;
			end
			S_CHECK: begin
				if (!stat.hit) begin
					state_nx = S_SCAN;
				end else if (stat.mode == MODE_LIST) begin
					state_nx = S_GROW;
				end else begin
					state_nx = S_OUT;
				end
			end
			S_FINISH: begin
				state_nx = S_OUT;
			end
			S_OUT_MID: begin
				if (rsp_ready) state_nx = S_SCAN;
			end
			S_OUT: begin
				if (rsp_ready) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.out_sel = OUT_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.req_load = req_valid;
			end
			S_DISPATCH: begin
				unique case (stat.mode)
					MODE_ADD: begin
						if (stat.add_full) begin
							cmd.out_sel = OUT_FULL;
						end else begin
							cmd.tbl_write = 1'b1;
							cmd.grow_go   = 1'b1;
						end
					end
					MODE_READ: begin
						if (stat.read_ok) begin
							cmd.idx_load_read = 1'b1;
						end else begin
							cmd.out_sel = OUT_MISS;
						end
					end
					MODE_CLEAR: begin
						cmd.tbl_clear = 1'b1;
						cmd.out_sel   = OUT_CLEAR;
					end
					MODE_FIND, MODE_LIST: begin
					end
					default: begin
						cmd.out_sel = OUT_MISS;
					end
				endcase
			end
			S_GROW: begin
				if (stat.grow_done) begin
					if (stat.mode == MODE_LIST) begin
						cmd.list_commit = 1'b1;
						if (stat.pend_valid) cmd.out_sel = OUT_PEND_MID;
					end else begin
						cmd.add_commit = 1'b1;
						cmd.out_sel    = OUT_ADD;
					end
				end
			end
			S_CHECK: begin
				if (!stat.hit) begin
					cmd.idx_inc = 1'b1;
				end else if (stat.mode == MODE_LIST) begin
					cmd.grow_go  = 1'b1;
					cmd.grow_sub = 1'b1;
				end else begin
					cmd.out_sel = OUT_ROW;
				end
			end
			S_FINISH: begin
				if (stat.mode == MODE_LIST) begin
					cmd.out_sel = stat.pend_valid ? OUT_PEND_LAST : OUT_LIST_NONE;
				end else begin
					cmd.out_sel = OUT_MISS;
				end
			end
			S_SCAN, S_OUT_MID, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT) || (state_q == S_OUT_MID);

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a result is pending");
	a_grow_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GROW && !stat.grow_done) |=> (state_q == S_GROW))
		else $error("left total update before it finished");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_write |-> (stat.mode == MODE_ADD && !stat.add_full))
		else $error("table write outside a legal add");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !rsp_ready) |=> (state_q == S_OUT))
		else $error("result dropped before transfer");
`endif

endmodule

>>> test/io_channel_map_table_test.sv
`timescale 1ns / 100ps
// Testbench for the I/O channel map table: drives add, find, read, list and clear
// requests and checks every response against a behavioral table model.
// Depends on icmt_pkg and io_channel_map_table.
module io_channel_map_table_test;
	import icmt_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	io_channel_map_table dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Model state of the channel table.
	entry_t      table_rows [MAX_ENTRIES_DEF];
	int          row_count;
	logic [12:0] bit_total;
	rsp_t        pending_rsps [$];

	int  errors;
	int  rsp_seen;
	int  list_rsps;
	int  idle_cycles = 0;
	bit  idle_on;
	int  sent_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Padded bit total after adding one channel.
	function automatic logic [12:0] padded_total(logic [12:0] t, logic [6:0] sz);
		int acc;
		acc = t;
		if (sz != 0 && sz % 8 == 0 && acc % sz != 0)
			acc = acc + sz - acc % sz;
		return 13'(acc + sz);
	endfunction

	function automatic logic [10:0] image_bytes_of(logic [12:0] t);
		int r;
		r = (int'(t) + 31) / 32 * 4;
		return 11'(r);
	endfunction

	function automatic rsp_t blank_rsp(logic [10:0] img);
		rsp_t r;
		r = '0;
		r.entry_count = 6'(row_count);
		r.image_bytes = img;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic rsp_t row_rsp(entry_t e, logic [10:0] img);
		rsp_t r;
		r = blank_rsp(img);
		r.found = 1'b1;
		r.out_size_bits = e.size_bits;
		r.out_byte_offset = e.byte_offset;
		r.out_bit_position = e.bit_position;
		return r;
	endfunction

	// Compute the responses one request causes and queue them.
	task automatic predict_table(req_t q);
		rsp_t r;
		entry_t e;
		logic [12:0] sub;
		int hits;
		int i;
		hits = 0;
		sub = '0;
		case (q.mode)
			MODE_ADD: begin
				if (row_count >= MAX_ENTRIES_DEF) begin
					r = blank_rsp(image_bytes_of(bit_total));
					r.table_full = 1'b1;
					pending_rsps.push_back(r);
				end else begin
					e = {q.node_id, q.module_id, q.channel_id, q.size_bits,
						q.byte_offset, q.bit_position};
					table_rows[row_count] = e;
					bit_total = padded_total(bit_total, q.size_bits);
					row_count++;
					pending_rsps.push_back(row_rsp(e, image_bytes_of(bit_total)));
				end
			end
			MODE_FIND: begin
				for (i = 0; i < row_count && hits == 0; i++) begin
					e = table_rows[i];
					if (e.node_id == q.node_id && e.module_id == q.module_id &&
						e.channel_id == q.channel_id) begin
						pending_rsps.push_back(row_rsp(e, image_bytes_of(bit_total)));
						hits = 1;
					end
				end
				if (hits == 0)
					pending_rsps.push_back(blank_rsp(image_bytes_of(bit_total)));
			end
			MODE_READ: begin
				if (q.entry_index < row_count)
					pending_rsps.push_back(row_rsp(table_rows[q.entry_index],
						image_bytes_of(bit_total)));
				else
					pending_rsps.push_back(blank_rsp(image_bytes_of(bit_total)));
			end
			MODE_LIST: begin
				for (i = 0; i < row_count && hits < RESULT_CAP; i++) begin
					e = table_rows[i];
					if (e.node_id == q.node_id && e.module_id == q.module_id) begin
						sub = padded_total(sub, e.size_bits);
						r = row_rsp(e, image_bytes_of(sub));
						r.last = 1'b0;
						pending_rsps.push_back(r);
						hits++;
					end
				end
				if (hits == 0)
					pending_rsps.push_back(blank_rsp('0));
				else
					pending_rsps[$].last = 1'b1;
			end
			MODE_CLEAR: begin
				row_count = 0;
				bit_total = '0;
				pending_rsps.push_back(blank_rsp('0));
			end
			default: pending_rsps.push_back(blank_rsp(image_bytes_of(bit_total)));
		endcase
	endtask

	function automatic bit should_idle();
		return idle_on && ($urandom_range(99) < 26);
	endfunction

	// Send one request; the valid stays high across back-to-back transfers.
	task automatic send_req(req_t q);
		while (should_idle()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_table(q);
		sent_items++;
	endtask

	function automatic req_t make_req(mode_t m, logic [7:0] nd, logic [7:0] md,
		logic [15:0] ch, logic [6:0] sz);
		req_t q;
		q.mode = m;
		q.node_id = nd;
		q.module_id = md;
		q.channel_id = ch;
		q.size_bits = sz;
		q.byte_offset = 16'($urandom);
		q.bit_position = 3'($urandom);
		q.entry_index = 5'($urandom);
		return q;
	endfunction

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
	endtask

	// Response checker and ready generator.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (pending_rsps.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", rsp);
			end else begin
				if (rsp !== pending_rsps[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h actual %h", pending_rsps[0], rsp);
				end
				if (!pending_rsps[0].last || pending_rsps[0].found) list_rsps++;
				void'(pending_rsps.pop_front());
			end
		end
		rsp_ready <= !should_idle();
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Extremes of the fields and each special case.
	task automatic test_directed();
		req_t q;
		send_req(make_req(MODE_READ, 8'd0, 8'd0, 16'd0, 7'd0));
		send_req(make_req(MODE_LIST, 8'd1, 8'd1, 16'd0, 7'd0));
		send_req(make_req(MODE_ADD, 8'hFF, 8'hFF, 16'hFFFF, 7'd0));
		send_req(make_req(MODE_ADD, 8'hFF, 8'hFF, 16'd1, 7'd3));
		send_req(make_req(MODE_ADD, 8'hFF, 8'hFF, 16'd2, 7'd64));
		send_req(make_req(MODE_ADD, 8'hFF, 8'hFF, 16'd3, 7'd16));
		send_req(make_req(MODE_ADD, 8'd0, 8'd0, 16'd0, 7'd8));
		send_req(make_req(MODE_ADD, 8'd0, 8'd0, 16'd7, 7'd127));
		q = make_req(MODE_ADD, 8'h5A, 8'hA5, 16'h1234, 7'd24);
		q.byte_offset = 16'hFFFF;
		q.bit_position = 3'd7;
		send_req(q);
		send_req(make_req(MODE_FIND, 8'hFF, 8'hFF, 16'hFFFF, 7'd0));
		send_req(make_req(MODE_FIND, 8'h12, 8'h34, 16'h5678, 7'd0));
		q = make_req(MODE_READ, 8'd0, 8'd0, 16'd0, 7'd0);
		q.entry_index = 5'd31;
		send_req(q);
		q.entry_index = 5'd0;
		send_req(q);
		send_req(make_req(MODE_LIST, 8'hFF, 8'hFF, 16'd0, 7'd0));
		q = make_req(MODE_CLEAR, 8'd0, 8'd0, 16'd0, 7'd0);
		q.mode = mode_t'(3'd5);
		send_req(q);
		q.mode = mode_t'(3'd7);
		send_req(q);
		send_req(make_req(MODE_CLEAR, 8'd0, 8'd0, 16'd0, 7'd0));
		send_req(make_req(MODE_FIND, 8'hFF, 8'hFF, 16'hFFFF, 7'd0));
	endtask

	task automatic q_read_all();
		req_t q;
		q = make_req(MODE_READ, 8'd0, 8'd0, 16'd0, 7'd0);
		q.entry_index = 5'd31;
		send_req(q);
	endtask

	// Fill the table past full with one module, then list it whole.
	task automatic test_full_table();
		int i;
		for (i = 0; i < MAX_ENTRIES_DEF + 2; i++)
			send_req(make_req(MODE_ADD, 8'h11, 8'h22, 16'(i), 7'($urandom_range(64))));
		send_req(make_req(MODE_LIST, 8'h11, 8'h22, 16'd0, 7'd0));
		q_read_all();
		wait_drained();
		send_req(make_req(MODE_CLEAR, 8'd0, 8'd0, 16'd0, 7'd0));
	endtask

	// Random mix over a few nodes and modules so finds and lists hit often.
	task automatic test_random(int count);
		req_t q;
		int n;
		int pick;
		for (n = 0; n < count; n++) begin
			if (n == count / 3) idle_on = 1'b0;
			if (n == count / 2) idle_on = 1'b1;
			pick = $urandom_range(99);
			q = make_req(MODE_ADD, 8'($urandom_range(3)), 8'($urandom_range(3)),
				16'($urandom_range(7)), 7'($urandom_range(64)));
			if (pick < 5) begin
				q.node_id = 8'($urandom);
				q.module_id = 8'($urandom);
				q.channel_id = 16'($urandom);
			end
			if (pick < 40) q.mode = MODE_ADD;
			else if (pick < 60) q.mode = MODE_FIND;
			else if (pick < 75) q.mode = MODE_READ;
			else if (pick < 90) q.mode = MODE_LIST;
			else if (pick < 94) q.mode = MODE_CLEAR;
			else q.mode = mode_t'(3'($urandom_range(7)));
			if (q.mode == MODE_READ && $urandom_range(1))
				q.entry_index = 5'($urandom_range(row_count > 0 ? row_count - 1 : 0));
			send_req(q);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		errors = 0;
		rsp_seen = 0;
		list_rsps = 0;
		idle_on = 1'b1;
		sent_items = 0;
		row_count = 0;
		bit_total = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_full_table();
		test_random(280);
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, checked %0d responses (%0d carrying an entry).",
			sent_items, rsp_seen, list_rsps);
		$display("Covered add with padding, full table, find, read, list and clear.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
